// ===== src/backup_power_switch_monitor_macros.svh =====
// Assertion helpers for the backup power switch monitor.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BACKUP_POWER_SWITCH_MONITOR_MACROS_SVH
`define BACKUP_POWER_SWITCH_MONITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPSM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpsm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpsm assertion failed");

`endif

// ===== src/bpsm_pkg.sv =====
package bpsm_pkg;

  localparam int THR_W     = 10;
  localparam int OFF_W     = 17;
  localparam int CLR_W     = 16;
  localparam int HOLD_W    = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int PORT_W    = 6;
  localparam int PHASE_W   = 2;

  // Phase codes.
  localparam logic [PHASE_W-1:0] PH_WAIT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MON  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_BATT = 2'd2;
  localparam logic [PHASE_W-1:0] PH_REST = 2'd3;

  // Output pin patterns.
  localparam logic [PORT_W-1:0] PAT_OFF  = 6'h00;
  localparam logic [PORT_W-1:0] PAT_GOOD = 6'h11;
  localparam logic [PORT_W-1:0] PAT_DIP  = 6'h12;
  localparam logic [PORT_W-1:0] PAT_BATT = 6'h1A;
  localparam logic [PORT_W-1:0] PAT_BOOT = 6'h31;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ARM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BATT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REST  = 3'd5;

  // Register reset values.
  localparam logic [THR_W-1:0]  ARM_RST   = 10'd120;
  localparam logic [THR_W-1:0]  GOOD_RST  = 10'd121;
  localparam logic [OFF_W-1:0]  OFF_RST   = 17'd100000;
  localparam logic [CLR_W-1:0]  CLEAR_RST = 16'd1000;
  localparam logic [HOLD_W-1:0] BATT_RST  = 24'd15000;
  localparam logic [HOLD_W-1:0] REST_RST  = 24'd2000;

  typedef struct packed {
    logic [THR_W-1:0]  arm_threshold;
    logic [THR_W-1:0]  good_threshold;
    logic [OFF_W-1:0]  off_timeout;
    logic [CLR_W-1:0]  clear_hold;
    logic [HOLD_W-1:0] battery_hold;
    logic [HOLD_W-1:0] rest_hold;
  } cfg_t;

  // Packed so that the port pattern sits in the low bits.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PORT_W-1:0]  port_value;
  } res_t;

endpackage

// ===== src/backup_power_switch_monitor.sv =====
// Channel  Direction  Transfer when          Payload
// in_      slave      in_tvalid & in_tready   in_tdata: sample
// out_     master     out_tvalid & out_tready out_tdata: port_value, phase
// cfg_     write      cfg_wr_en               cfg_index selects, cfg_wdata holds value
//
// One item per cycle while in_tready is high. The result of an item is registered
// before it shows on out_; the phase and counter update is a single compare and
// decrement stage. A two-entry output buffer (output register plus skid register)
// lets one more item in while out_tready is low; in_tready drops once both are full.
// rst_n is synchronous and restores the register defaults and the boot pattern.
module backup_power_switch_monitor #(
  parameter int SAMPLE_WIDTH = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // [SAMPLE_WIDTH-1:0] sample, zero padding above
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [5:0] port_value, [7:6] phase
  output logic [7:0]                           out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wr_en,
  input  logic [bpsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpsm_pkg::CFG_W-1:0]           cfg_wdata
);

  bpsm_pkg::cfg_t cfg_r;
  bpsm_pkg::res_t res;
  bpsm_pkg::res_t out_data_r, skid_data_r;
  logic           out_valid_r, skid_valid_r;
  logic           in_fire;
  logic           out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm_threshold  <= bpsm_pkg::ARM_RST;
      cfg_r.good_threshold <= bpsm_pkg::GOOD_RST;
      cfg_r.off_timeout    <= bpsm_pkg::OFF_RST;
      cfg_r.clear_hold     <= bpsm_pkg::CLEAR_RST;
      cfg_r.battery_hold   <= bpsm_pkg::BATT_RST;
      cfg_r.rest_hold      <= bpsm_pkg::REST_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpsm_pkg::REG_ARM:   cfg_r.arm_threshold  <= cfg_wdata[bpsm_pkg::THR_W-1:0];
        bpsm_pkg::REG_GOOD:  cfg_r.good_threshold <= cfg_wdata[bpsm_pkg::THR_W-1:0];
        bpsm_pkg::REG_OFF:   cfg_r.off_timeout    <= cfg_wdata[bpsm_pkg::OFF_W-1:0];
        bpsm_pkg::REG_CLEAR: cfg_r.clear_hold     <= cfg_wdata[bpsm_pkg::CLR_W-1:0];
        bpsm_pkg::REG_BATT:  cfg_r.battery_hold   <= cfg_wdata[bpsm_pkg::HOLD_W-1:0];
        bpsm_pkg::REG_REST:  cfg_r.rest_hold      <= cfg_wdata[bpsm_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = !out_valid_r || out_tready;

  bpsm_core #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_fire),
    .sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .cfg    (cfg_r),
    .res    (res)
  );

  // The skid register only fills while the output register is stalled, and it
  // drains into the output register before any new result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= res;
      end
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "backup_power_switch_monitor_macros.svh"

  `BPSM_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  `BPSM_ASSERT_NEXT(a_stall_fills_skid, in_fire && out_valid_r && !out_tready, skid_valid_r)
  `BPSM_ASSERT_SAME(a_rest_is_off, out_valid_r && out_data_r.phase == bpsm_pkg::PH_REST, out_data_r.port_value == bpsm_pkg::PAT_OFF)
  `BPSM_ASSERT_SAME(a_batt_pattern, out_valid_r && out_data_r.phase == bpsm_pkg::PH_BATT, out_data_r.port_value == bpsm_pkg::PAT_BATT)

endmodule

// ===== src/bpsm_core.sv =====
module bpsm_core #(
  parameter int SAMPLE_WIDTH = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  bpsm_pkg::cfg_t          cfg,
  output bpsm_pkg::res_t          res
);

  localparam int CMP_W = (SAMPLE_WIDTH > bpsm_pkg::THR_W) ? SAMPLE_WIDTH : bpsm_pkg::THR_W;

  logic [bpsm_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [bpsm_pkg::PORT_W-1:0]  port_r, port_nxt;
  logic [SAMPLE_WIDTH-1:0]      prev_r, prev_nxt;
  logic [bpsm_pkg::OFF_W-1:0]   off_r, off_nxt, off_mid;
  logic [bpsm_pkg::CLR_W-1:0]   hold_r, hold_nxt;
  logic [bpsm_pkg::HOLD_W-1:0]  delay_r, delay_nxt;
  logic                         enter_batt;

  logic [CMP_W-1:0] s_ext, prev_ext, arm_ext, good_ext;
  logic             s_good, prev_good;

  assign s_ext     = CMP_W'(sample);
  assign prev_ext  = CMP_W'(prev_r);
  assign arm_ext   = CMP_W'(cfg.arm_threshold);
  assign good_ext  = CMP_W'(cfg.good_threshold);
  assign s_good    = s_ext > good_ext;
  assign prev_good = prev_ext > good_ext;

  always_comb begin
    phase_nxt  = phase_r;
    port_nxt   = port_r;
    prev_nxt   = prev_r;
    off_mid    = off_r;
    hold_nxt   = hold_r;
    delay_nxt  = delay_r;
    enter_batt = 1'b0;
    case (phase_r)
      bpsm_pkg::PH_WAIT: begin
        // Arming keeps no sample; the pattern changes only to battery.
        if (s_ext < arm_ext) begin
          port_nxt = bpsm_pkg::PAT_OFF;
        end else begin
          phase_nxt  = bpsm_pkg::PH_MON;
          off_mid    = cfg.off_timeout;
          enter_batt = (cfg.off_timeout == '0);
        end
      end
      bpsm_pkg::PH_MON: begin
        prev_nxt = sample;
        if (s_good && prev_good) begin
          off_mid = cfg.off_timeout;
          if (hold_r == '0) begin
            port_nxt = bpsm_pkg::PAT_GOOD;
          end else begin
            hold_nxt = hold_r - 1'b1;
          end
        end else if (!s_good) begin
          if (off_r != '0) begin
            off_mid = off_r - 1'b1;
          end
          hold_nxt = cfg.clear_hold;
          port_nxt = bpsm_pkg::PAT_DIP;
        end
        enter_batt = (off_mid == '0);
      end
      bpsm_pkg::PH_BATT: begin
        if (delay_r <= bpsm_pkg::HOLD_W'(1)) begin
          phase_nxt = bpsm_pkg::PH_REST;
          port_nxt  = bpsm_pkg::PAT_OFF;
          delay_nxt = cfg.rest_hold;
        end else begin
          delay_nxt = delay_r - 1'b1;
        end
      end
      default: begin
        if (delay_r <= bpsm_pkg::HOLD_W'(1)) begin
          phase_nxt = bpsm_pkg::PH_WAIT;
          port_nxt  = bpsm_pkg::PAT_OFF;
          delay_nxt = '0;
        end else begin
          delay_nxt = delay_r - 1'b1;
        end
      end
    endcase
    off_nxt = off_mid;
    if (enter_batt) begin
      phase_nxt = bpsm_pkg::PH_BATT;
      port_nxt  = bpsm_pkg::PAT_BATT;
      delay_nxt = cfg.battery_hold;
    end
  end

  assign res.phase      = phase_nxt;
  assign res.port_value = port_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bpsm_pkg::PH_WAIT;
      port_r  <= bpsm_pkg::PAT_BOOT;
      prev_r  <= '0;
      off_r   <= bpsm_pkg::OFF_RST;
      hold_r  <= '0;
      delay_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      port_r  <= port_nxt;
      prev_r  <= prev_nxt;
      off_r   <= off_nxt;
      hold_r  <= hold_nxt;
      delay_r <= delay_nxt;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int SMP_W = 10;
  localparam int IN_W  = ((SMP_W + 7) / 8) * 8;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic [IN_W-1:0]                in_tdata = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     out_tdata;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [bpsm_pkg::CFG_IDX_W-1:0] cfg_index = bpsm_pkg::REG_ARM;
  logic [bpsm_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // Shadow of the register file and of the switch state, as the block should hold them.
  bpsm_pkg::cfg_t               limits;
  logic [bpsm_pkg::PHASE_W-1:0] sw_phase;
  logic [bpsm_pkg::PORT_W-1:0]  sw_pins;
  logic [SMP_W-1:0]             last_smp;
  logic [bpsm_pkg::OFF_W-1:0]   off_cnt;
  logic [bpsm_pkg::CLR_W-1:0]   clr_cnt;
  logic [bpsm_pkg::HOLD_W-1:0]  dly_cnt;

  logic [SMP_W-1:0] sample_q[$];
  bpsm_pkg::res_t   pin_expect_q[$];
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  logic             hold_rx = 1'b0;
  int               test_phase = -1;
  int unsigned      mismatches = 0;

  backup_power_switch_monitor #(.SAMPLE_WIDTH(SMP_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),   // [9:0] sample, zero padding above
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),  // [5:0] port_value, [7:6] phase
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic reset_switch_model();
    limits.arm_threshold  = bpsm_pkg::ARM_RST;
    limits.good_threshold = bpsm_pkg::GOOD_RST;
    limits.off_timeout    = bpsm_pkg::OFF_RST;
    limits.clear_hold     = bpsm_pkg::CLEAR_RST;
    limits.battery_hold   = bpsm_pkg::BATT_RST;
    limits.rest_hold      = bpsm_pkg::REST_RST;
    sw_phase = bpsm_pkg::PH_WAIT;
    sw_pins  = bpsm_pkg::PAT_BOOT;
    last_smp = '0;
    off_cnt  = bpsm_pkg::OFF_RST;
    clr_cnt  = '0;
    dly_cnt  = '0;
  endtask

  function automatic void go_battery();
    sw_phase = bpsm_pkg::PH_BATT;
    sw_pins  = bpsm_pkg::PAT_BATT;
    dly_cnt  = limits.battery_hold;
  endfunction

  function automatic bpsm_pkg::res_t step_switch_model(input logic [SMP_W-1:0] smp);
    bpsm_pkg::res_t   r;
    logic [SMP_W-1:0] prev;
    case (sw_phase)
      bpsm_pkg::PH_WAIT: begin
        if (smp < limits.arm_threshold) begin
          sw_pins = bpsm_pkg::PAT_OFF;
        end else begin
          // Arming leaves the stored sample alone, and the pin pattern unless it goes to battery.
          sw_phase = bpsm_pkg::PH_MON;
          off_cnt  = limits.off_timeout;
          if (off_cnt == '0) go_battery();
        end
      end
      bpsm_pkg::PH_MON: begin
        prev     = last_smp;
        last_smp = smp;
        if (smp > limits.good_threshold && prev > limits.good_threshold) begin
          off_cnt = limits.off_timeout;
          if (clr_cnt == '0) sw_pins = bpsm_pkg::PAT_GOOD;
          else clr_cnt = clr_cnt - 1'b1;
        end
        if (smp <= limits.good_threshold) begin
          if (off_cnt != '0) off_cnt = off_cnt - 1'b1;
          clr_cnt = limits.clear_hold;
          sw_pins = bpsm_pkg::PAT_DIP;
        end
        if (off_cnt == '0) go_battery();
      end
      bpsm_pkg::PH_BATT: begin
        if (dly_cnt <= 1) begin
          sw_phase = bpsm_pkg::PH_REST;
          sw_pins  = bpsm_pkg::PAT_OFF;
          dly_cnt  = limits.rest_hold;
        end else begin
          dly_cnt = dly_cnt - 1'b1;
        end
      end
      default: begin
        if (dly_cnt <= 1) begin
          sw_phase = bpsm_pkg::PH_WAIT;
          sw_pins  = bpsm_pkg::PAT_OFF;
          dly_cnt  = '0;
        end else begin
          dly_cnt = dly_cnt - 1'b1;
        end
      end
    endcase
    r.phase      = sw_phase;
    r.port_value = sw_pins;
    return r;
  endfunction

  // Sender: a transfer is predicted at the edge where it happens.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pin_expect_q.push_back(step_switch_model(in_tdata[SMP_W-1:0]));
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'(sample_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    bpsm_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pin_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = pin_expect_q.pop_front();
        if (got.port_value !== want.port_value)
          report_mismatch($sformatf("port_value %h, expected %h", got.port_value,
                                    want.port_value));
        if (got.phase !== want.phase)
          report_mismatch($sformatf("phase %0d, expected %0d", got.phase, want.phase));
      end
    end
    out_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
  end

  // Long receiver hold-off while the sender keeps offering, so the input stalls.
  initial begin
    wait (test_phase == 2);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input logic [bpsm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpsm_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bpsm_pkg::REG_ARM:   limits.arm_threshold  = val[bpsm_pkg::THR_W-1:0];
      bpsm_pkg::REG_GOOD:  limits.good_threshold = val[bpsm_pkg::THR_W-1:0];
      bpsm_pkg::REG_OFF:   limits.off_timeout    = val[bpsm_pkg::OFF_W-1:0];
      bpsm_pkg::REG_CLEAR: limits.clear_hold     = val[bpsm_pkg::CLR_W-1:0];
      bpsm_pkg::REG_BATT:  limits.battery_hold   = val[bpsm_pkg::HOLD_W-1:0];
      bpsm_pkg::REG_REST:  limits.rest_hold      = val[bpsm_pkg::HOLD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Bits above each register's width carry junk, which the block must ignore.
  task automatic program_limits(input int unsigned arm, good, off, clr, batt, rest);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(bpsm_pkg::REG_ARM,   {junk[13:0], bpsm_pkg::THR_W'(arm)});
    write_reg(bpsm_pkg::REG_GOOD,  {junk[27:14], bpsm_pkg::THR_W'(good)});
    write_reg(bpsm_pkg::REG_OFF,   {junk[6:0], bpsm_pkg::OFF_W'(off)});
    write_reg(bpsm_pkg::REG_CLEAR, {junk[15:8], bpsm_pkg::CLR_W'(clr)});
    write_reg(bpsm_pkg::REG_BATT,  bpsm_pkg::HOLD_W'(batt));
    write_reg(bpsm_pkg::REG_REST,  bpsm_pkg::HOLD_W'(rest));
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_tvalid || pin_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SMP_W-1:0] pick_sample(input int kind);
    logic [SMP_W-1:0] g, a;
    g = limits.good_threshold;
    a = limits.arm_threshold;
    case (kind)
      0: return (g == '1) ? g : SMP_W'($urandom_range(1023, g + 1));
      1: return SMP_W'($urandom_range(g, 0));
      2: begin
        case ($urandom_range(5))
          0: return a;
          1: return a - 1'b1;
          2: return g;
          3: return g + 1'b1;
          4: return '0;
          default: return '1;
        endcase
      end
      default: return SMP_W'($urandom_range(1023, 0));
    endcase
  endfunction

  // Runs of good or low supply, so that dips, recoveries and timeouts all occur.
  task automatic queue_runs(input int count);
    int n, kind, len;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(3);
      len  = $urandom_range(8, 1);
      repeat (len) begin
        sample_q.push_back(pick_sample(kind));
        n++;
      end
    end
  endtask

  initial begin
    int          dir_a[7]  = '{1023, 1023, 1023, 121, 122, 122, 0};
    int          dir_b[10] = '{5, 7, 0, 300, 301, 1022, 1023, 0, 9, 9};
    int          dir_c[8]  = '{0, 1, 2, 3, 512, 4, 5, 6};
    int unsigned arm_set[8]   = '{100, 600, 1023, 0, 512, 50, 1023, 200};
    int unsigned good_set[8]  = '{400, 300, 1022, 0, 512, 1023, 1023, 700};
    int unsigned off_set[8]   = '{3, 5, 2, 1, 8, 1, 131071, 4};
    int unsigned clr_set[8]   = '{2, 1, 0, 3, 4, 65535, 65535, 2};
    int unsigned batt_set[8]  = '{4, 1, 0, 6, 3, 2, 16777215, 2};
    int unsigned rest_set[8]  = '{3, 2, 0, 1, 5, 2, 16777215, 1};
    int unsigned tx_set[8]    = '{0, 53, 0, 0, 31, 53, 0, 31};
    int unsigned rx_set[8]    = '{0, 0, 0, 53, 31, 0, 53, 31};

    reset_switch_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults first: arming at the boot pattern, a dip and a recovery.
    foreach (dir_a[i]) sample_q.push_back(SMP_W'(dir_a[i]));
    wait_idle();
    // Timeout of one: battery after a single dip, holds of zero and one, back to waiting.
    program_limits(1023, 0, 1, 0, 0, 1);
    foreach (dir_b[i]) sample_q.push_back(SMP_W'(dir_b[i]));
    wait_idle();
    // Timeout of zero: arming goes straight to battery.
    program_limits(0, 1023, 0, 65535, 2, 0);
    foreach (dir_c[i]) sample_q.push_back(SMP_W'(dir_c[i]));
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      program_limits(arm_set[p], good_set[p], off_set[p], clr_set[p], batt_set[p],
                     rest_set[p]);
      tx_idle_pct  = tx_set[p];
      rx_stall_pct = rx_set[p];
      test_phase   = p;
      queue_runs((p == 6) ? 40 : 185);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
